/* sv/dsg_pkg.sv */
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared widths, codes and item types of the distance speed governor.
// ----------------------------------------------------------------------------
package dsg_pkg;

	localparam int DISTANCE_BITS = 12;
	localparam int CFG_W         = 12;
	localparam int GAIN_W        = 8;
	localparam int RATIO_CFG_W   = 8;
	localparam int WHEEL_W       = 10;
	localparam int FRAC_W        = 8;
	localparam int SPEED_FRAC_W  = 4;
	localparam int OUT_W         = 18;
	localparam int IDX_W         = 3;

	localparam int CMP_W   = (DISTANCE_BITS > CFG_W) ? DISTANCE_BITS : CFG_W;
	localparam int TGT_W   = GAIN_W + CMP_W;
	localparam int SPEED_W = CFG_W + SPEED_FRAC_W;
	localparam int RATIO_W = WHEEL_W + FRAC_W;
	localparam int PROD_W  = TGT_W + RATIO_W - FRAC_W;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam logic [CFG_W-1:0]       RST_SAFETY   = CFG_W'(150);
	localparam logic [CFG_W-1:0]       RST_DROP     = CFG_W'(150);
	localparam logic [GAIN_W-1:0]      RST_GAIN     = GAIN_W'(24);
	localparam logic [CFG_W-1:0]       RST_STRAIGHT = CFG_W'(150);
	localparam logic [CFG_W-1:0]       RST_KEEP     = CFG_W'(250);
	localparam logic [CFG_W-1:0]       RST_CHANGE   = CFG_W'(300);
	localparam logic [CFG_W-1:0]       RST_MIN      = CFG_W'(40);
	localparam logic [RATIO_CFG_W-1:0] RST_RATIO    = RATIO_CFG_W'(205);

	typedef enum logic [IDX_W-1:0] {
		REG_SAFETY   = 3'd0,
		REG_DROP     = 3'd1,
		REG_GAIN     = 3'd2,
		REG_STRAIGHT = 3'd3,
		REG_KEEP     = 3'd4,
		REG_CHANGE   = 3'd5,
		REG_MIN      = 3'd6,
		REG_RATIO    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_STRAIGHT = 2'd0,
		MODE_RIGHT    = 2'd1,
		MODE_LEFT     = 2'd2,
		MODE_OTHER    = 2'd3
	} mode_t;

	localparam logic [1:0] LANE_KEEP   = 2'd0;
	localparam logic [1:0] LANE_SWITCH = 2'd1;

	typedef struct packed {
		logic [DISTANCE_BITS-1:0] obstacle_range;
		logic [1:0]               drive_mode;
		logic [1:0]               lane_function;
		logic [WHEEL_W-1:0]       left_wheel_speed;
		logic [WHEEL_W-1:0]       right_wheel_speed;
		logic                     hold_stop;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] left_target;
		logic [OUT_W-1:0] right_target;
		logic             command_valid;
		logic             stop_state;
		logic             emergency_brake;
		logic             reverse_motor;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0]       stop_range;
		logic [CFG_W-1:0]       sudden_drop;
		logic [GAIN_W-1:0]      gain;
		logic [CFG_W-1:0]       straight_max;
		logic [CFG_W-1:0]       keep_max;
		logic [CFG_W-1:0]       change_max;
		logic [CFG_W-1:0]       speed_floor;
		logic [RATIO_CFG_W-1:0] default_ratio;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic clamp;
		logic div_start;
		logic scale;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic need_scale;
		logic div_done;
	} sts_t;

	function automatic logic [OUT_W-1:0] sat_out(input logic [PROD_W-1:0] v);
		logic [OUT_W-1:0] r;
		r = (v > PROD_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
		return r;
	endfunction

endpackage

/* sv/dsg_in_if.sv */
// ----------------------------------------------------------------------------
// dsg_in_if
// Valid/ready channel that carries one control tick item per beat.
// ----------------------------------------------------------------------------
interface dsg_in_if;
	logic               valid;
	logic               ready;
	dsg_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/dsg_out_if.sv */
// ----------------------------------------------------------------------------
// dsg_out_if
// Valid/ready channel that carries one wheel speed command per beat.
// ----------------------------------------------------------------------------
interface dsg_out_if;
	logic               valid;
	logic               ready;
	dsg_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/dsg_cfg.sv */
// ----------------------------------------------------------------------------
// dsg_cfg
// Configuration register file written through a plain indexed write port.
// ----------------------------------------------------------------------------
module dsg_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dsg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dsg_pkg::CFG_W-1:0]    cfg_data,
	output dsg_pkg::cfg_t                cfg
);
	import dsg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_range      <= RST_SAFETY;
			cfg_q.sudden_drop     <= RST_DROP;
			cfg_q.gain            <= RST_GAIN;
			cfg_q.straight_max    <= RST_STRAIGHT;
			cfg_q.keep_max        <= RST_KEEP;
			cfg_q.change_max      <= RST_CHANGE;
			cfg_q.speed_floor     <= RST_MIN;
			cfg_q.default_ratio   <= RST_RATIO;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SAFETY:   cfg_q.stop_range      <= cfg_data;
				REG_DROP:     cfg_q.sudden_drop     <= cfg_data;
				REG_GAIN:     cfg_q.gain            <= cfg_data[GAIN_W-1:0];
				REG_STRAIGHT: cfg_q.straight_max    <= cfg_data;
				REG_KEEP:     cfg_q.keep_max        <= cfg_data;
				REG_CHANGE:   cfg_q.change_max      <= cfg_data;
				REG_MIN:      cfg_q.speed_floor     <= cfg_data;
				REG_RATIO:    cfg_q.default_ratio   <= cfg_data[RATIO_CFG_W-1:0];
				default:      cfg_q.stop_range      <= cfg_q.stop_range;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/dsg_div.sv */
// ----------------------------------------------------------------------------
// dsg_div
// Restoring divider for the wheel ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsg_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dsg_pkg::WHEEL_W-1:0]    num,
	input  logic [dsg_pkg::WHEEL_W-1:0]    den,
	output logic [dsg_pkg::RATIO_W-1:0]    quotient,
	output logic                           done
);
	import dsg_pkg::*;

	localparam int CNT_W = $clog2(RATIO_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [WHEEL_W-1:0] rem_q;
	logic [RATIO_W-1:0] quo_q;
	logic [WHEEL_W:0]   rem_sh;
	logic [WHEEL_W:0]   rem_sub;
	logic               ge;

	assign rem_sh  = {rem_q, quo_q[RATIO_W-1]};
	assign ge      = rem_sh >= {1'b0, den};
	assign rem_sub = rem_sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(RATIO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= {num, {FRAC_W{1'b0}}};
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_sub[WHEEL_W-1:0] : rem_sh[WHEEL_W-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = (cnt_q == '0);

endmodule

/* sv/dsg_dp.sv */
// ----------------------------------------------------------------------------
// dsg_dp
// Datapath: distance checks, latched flags, target speed, clamp and wheel scaling.
// ----------------------------------------------------------------------------
module dsg_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  dsg_pkg::cfg_t       cfg,
	input  dsg_pkg::cmd_t       cmd,
	input  dsg_pkg::in_item_t   item_data,
	output dsg_pkg::sts_t       sts,
	output dsg_pkg::out_item_t  result
);
	import dsg_pkg::*;

	logic [DISTANCE_BITS-1:0] dist_q;
	mode_t                    mode_q;
	logic [1:0]               lane_q;
	logic [WHEEL_W-1:0]       lw_q;
	logic [WHEEL_W-1:0]       rw_q;
	logic                     hold_q;

	logic [DISTANCE_BITS-1:0] prev_q;
	logic                     stop_q;
	logic                     emerg_q;
	logic                     rev_q;

	logic [TGT_W-1:0]         target_q;
	logic [PROD_W-1:0]        inner_q;
	out_item_t                result_q;

	logic [CMP_W-1:0]         dist_x;
	logic [CMP_W-1:0]         prev_x;
	logic [CMP_W-1:0]         safety_x;
	logic [CMP_W-1:0]         drop_x;
	logic [CMP_W-1:0]         clear_x;
	logic                     sudden;
	logic                     close;

	logic                     ceil_on;
	logic [SPEED_W-1:0]       ceil_v;
	logic [SPEED_W-1:0]       floor_v;

	logic                     turn;
	logic [WHEEL_W-1:0]       num;
	logic [WHEEL_W-1:0]       den;
	logic                     den_zero;
	logic [RATIO_W-1:0]       quotient;
	logic [RATIO_W-1:0]       ratio;
	logic                     div_done;
	logic [TGT_W+RATIO_W-1:0] product;

	logic [PROD_W-1:0]        tgt_w;
	logic [OUT_W-1:0]         tgt_sat;
	logic [OUT_W-1:0]         inner_sat;
	out_item_t                result_d;

	assign dist_x   = CMP_W'(dist_q);
	assign prev_x   = CMP_W'(prev_q);
	assign safety_x = CMP_W'(cfg.stop_range);
	assign drop_x   = CMP_W'(cfg.sudden_drop);
	assign clear_x  = dist_x - safety_x;
	assign sudden   = (prev_x > dist_x) && ((prev_x - dist_x) > drop_x) && (dist_x < safety_x);
	assign close    = (dist_x <= safety_x);

	always_comb begin
		ceil_on = 1'b1;
		ceil_v  = '0;
		priority if (mode_q == MODE_STRAIGHT) begin
			ceil_v = {cfg.straight_max, {SPEED_FRAC_W{1'b0}}};
		end else if (lane_q == LANE_KEEP) begin
			ceil_v = {cfg.keep_max, {SPEED_FRAC_W{1'b0}}};
		end else if (lane_q == LANE_SWITCH) begin
			ceil_v = {cfg.change_max, {SPEED_FRAC_W{1'b0}}};
		end else begin
			ceil_on = 1'b0;
		end
	end

	assign floor_v = {cfg.speed_floor, {SPEED_FRAC_W{1'b0}}};

	assign turn     = (mode_q == MODE_RIGHT) || (mode_q == MODE_LEFT);
	assign num      = (mode_q == MODE_RIGHT) ? rw_q : lw_q;
	assign den      = (mode_q == MODE_RIGHT) ? lw_q : rw_q;
	assign den_zero = (den == '0);
	assign ratio    = den_zero ? RATIO_W'(cfg.default_ratio) : quotient;
	assign product  = (TGT_W+RATIO_W)'(target_q) * (TGT_W+RATIO_W)'(ratio);

	dsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (num),
		.den      (den),
		.quotient (quotient),
		.done     (div_done)
	);

	assign sts.need_div   = turn && !stop_q && !den_zero;
	assign sts.need_scale = turn && !stop_q;
	assign sts.div_done   = div_done;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dist_q <= item_data.obstacle_range;
			mode_q <= mode_t'(item_data.drive_mode);
			lane_q <= item_data.lane_function;
			lw_q   <= item_data.left_wheel_speed;
			rw_q   <= item_data.right_wheel_speed;
			hold_q <= item_data.hold_stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			stop_q  <= 1'b0;
			emerg_q <= 1'b0;
		end else if (cmd.eval) begin
			prev_q <= dist_q;
			priority if (sudden) begin
				stop_q  <= 1'b1;
				emerg_q <= 1'b1;
			end else if (close) begin
				stop_q <= 1'b1;
			end else begin
				if (!hold_q) begin
					stop_q <= 1'b0;
				end
				emerg_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			rev_q    <= sudden;
			target_q <= close ? '0 : TGT_W'(cfg.gain) * TGT_W'(clear_x);
		end else if (cmd.clamp) begin
			if (ceil_on && !stop_q) begin
				priority if (target_q > TGT_W'(ceil_v)) begin
					target_q <= TGT_W'(ceil_v);
				end else if (target_q < TGT_W'(floor_v)) begin
					target_q <= TGT_W'(floor_v);
				end else begin
					target_q <= target_q;
				end
			end
		end
		if (cmd.scale) begin
			inner_q <= product[TGT_W+RATIO_W-1:FRAC_W];
		end
	end

	assign tgt_w     = PROD_W'(target_q);
	assign tgt_sat   = sat_out(tgt_w);
	assign inner_sat = sat_out(inner_q);

	always_comb begin
		result_d                 = '0;
		result_d.command_valid   = 1'b1;
		result_d.stop_state      = stop_q;
		result_d.emergency_brake = emerg_q;
		result_d.reverse_motor   = rev_q;
		if (!stop_q) begin
			unique case (mode_q)
				MODE_STRAIGHT: begin
					result_d.left_target  = tgt_sat;
					result_d.right_target = tgt_sat;
				end
				MODE_RIGHT: begin
					result_d.left_target  = tgt_sat;
					result_d.right_target = inner_sat;
				end
				MODE_LEFT: begin
					result_d.left_target  = inner_sat;
					result_d.right_target = tgt_sat;
				end
				MODE_OTHER: begin
					result_d.command_valid = 1'b0;
				end
				default: begin
					result_d.command_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;

endmodule

/* sv/dsg_ctrl.sv */
// ----------------------------------------------------------------------------
// dsg_ctrl
// Sequencer that steps one tick item through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module dsg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  dsg_pkg::sts_t  sts,
	output dsg_pkg::cmd_t  cmd
);
	import dsg_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EVAL  = 6'b000010,
		S_CLAMP = 6'b000100,
		S_DIV   = 6'b001000,
		S_SCALE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp     = 1'b1;
				cmd.div_start = sts.need_div;
				priority if (sts.need_div) begin
					state_d = S_DIV;
				end else if (sts.need_scale) begin
					state_d = S_SCALE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/distance_speed_governor.sv */
// ----------------------------------------------------------------------------
// distance_speed_governor
// Per-tick wheel speed governor driven by the front distance to an obstacle.
// ----------------------------------------------------------------------------
// One tick item is worked on at a time. A straight, other-mode or stopped
// tick goes from the accepting beat through the evaluate, clamp and done
// states; a turn with a zero reference wheel adds the scale state, and a turn
// that needs the measured wheel ratio also waits in the divide state for the
// restoring divider, which produces one of the eighteen ratio bits per cycle.
// The next tick can be accepted in the cycle after the result is loaded. The
// result sits in an output register, so the next tick is taken while it waits.
// Configuration registers are written through the indexed write port.
module distance_speed_governor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dsg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dsg_pkg::CFG_W-1:0]    cfg_data,
	dsg_in_if.sink                       item,
	dsg_out_if.source                    result
);
	import dsg_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	dsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dsg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.item_data (item.data),
		.sts       (sts),
		.result    (result.data)
	);

endmodule
